FILE: rtl/best_fit_partition_allocator_unit_defines.svh
// Assertion macros shared by the best-fit partition allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bfpa_pkg.sv
// Shared types and constants of the best-fit partition allocator.
// Depends on nothing; used by the interfaces, the cell and the top level.
package bfpa_pkg;

  localparam int ActionW         = 2;
  localparam int SizeFieldW      = 16;
  localparam int IdxFieldW       = 4;
  localparam int DefaultMaxBlocks = 16;
  localparam int DefaultSizeBits = 16;

  typedef enum logic [ActionW-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_ALLOC = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Control part of the search token that walks along the cell chain.
  typedef struct packed {
    logic vld;
    logic found;
  } tok_ctrl_t;

  // Control part of the broadcast table write.
  typedef struct packed {
    logic en;
    logic set_total;
  } wr_ctrl_t;

endpackage

FILE: rtl/bfpa_in_if.sv
// Request channel of the best-fit partition allocator.
// Depends on bfpa_pkg for the field widths.
interface bfpa_in_if;
  logic                               valid;
  logic                               ready;
  logic [bfpa_pkg::ActionW-1:0]       action;
  logic [bfpa_pkg::SizeFieldW-1:0]    item_size;

  modport source (output valid, output action, output item_size, input ready);
  modport sink   (input valid, input action, input item_size, output ready);
endinterface

FILE: rtl/bfpa_out_if.sv
// Result channel of the best-fit partition allocator.
// Depends on bfpa_pkg for the field widths.
interface bfpa_out_if;
  logic                               valid;
  logic                               ready;
  logic                               ok;
  logic [bfpa_pkg::IdxFieldW-1:0]     block_index;
  logic [bfpa_pkg::SizeFieldW-1:0]    block_total;
  logic [bfpa_pkg::SizeFieldW-1:0]    left_over;

  modport source (output valid, output ok, output block_index, output block_total,
                  output left_over, input ready);
  modport sink   (input valid, input ok, input block_index, input block_total,
                  input left_over, output ready);
endinterface

FILE: rtl/bfpa_cell.sv
// One partition cell: holds a total and a remaining size, and updates the
// passing search token. Depends on bfpa_pkg.
module bfpa_cell #(
  parameter int CELL_ID    = 0,
  parameter int MAX_BLOCKS = bfpa_pkg::DefaultMaxBlocks,
  parameter int SIZE_BITS  = bfpa_pkg::DefaultSizeBits,
  localparam int IdxW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CntW      = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CntW-1:0]      count_i,
  input  bfpa_pkg::tok_ctrl_t  tok_ctrl_i,
  input  logic [SIZE_BITS-1:0] tok_req_i,
  input  logic [IdxW-1:0]      tok_idx_i,
  input  logic [SIZE_BITS-1:0] tok_rem_i,
  input  logic [SIZE_BITS-1:0] tok_total_i,
  output bfpa_pkg::tok_ctrl_t  tok_ctrl_o,
  output logic [SIZE_BITS-1:0] tok_req_o,
  output logic [IdxW-1:0]      tok_idx_o,
  output logic [SIZE_BITS-1:0] tok_rem_o,
  output logic [SIZE_BITS-1:0] tok_total_o,
  input  bfpa_pkg::wr_ctrl_t   wr_ctrl_i,
  input  logic [IdxW-1:0]      wr_idx_i,
  input  logic [SIZE_BITS-1:0] wr_total_i,
  input  logic [SIZE_BITS-1:0] wr_rem_i
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CELL_ID);
  localparam logic [CntW-1:0] MyCnt = CntW'(CELL_ID);

  logic [SIZE_BITS-1:0] total_q;
  logic [SIZE_BITS-1:0] rem_q;
  bfpa_pkg::tok_ctrl_t  tok_ctrl_q;
  logic [SIZE_BITS-1:0] tok_req_q, tok_rem_q, tok_total_q;
  logic [IdxW-1:0]      tok_idx_q;
  logic                 active;
  logic                 take;
  logic                 wr_hit;

  // Only entries below the fill count take part in the search.
  assign active = (MyCnt < count_i);
  assign take   = tok_ctrl_i.vld && active && (rem_q >= tok_req_i) &&
                  (!tok_ctrl_i.found || (rem_q < tok_rem_i));
  assign wr_hit = wr_ctrl_i.en && (wr_idx_i == MyIdx);

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      rem_q <= wr_rem_i;
      if (wr_ctrl_i.set_total) begin
        total_q <= wr_total_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_ctrl_q <= '0;
    end else begin
      tok_ctrl_q.vld   <= tok_ctrl_i.vld;
      tok_ctrl_q.found <= tok_ctrl_i.found || take;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_req_q <= tok_req_i;
    if (take) begin
      tok_idx_q   <= MyIdx;
      tok_rem_q   <= rem_q;
      tok_total_q <= total_q;
    end else begin
      tok_idx_q   <= tok_idx_i;
      tok_rem_q   <= tok_rem_i;
      tok_total_q <= tok_total_i;
    end
  end

  assign tok_ctrl_o  = tok_ctrl_q;
  assign tok_req_o   = tok_req_q;
  assign tok_idx_o   = tok_idx_q;
  assign tok_rem_o   = tok_rem_q;
  assign tok_total_o = tok_total_q;

endmodule

FILE: rtl/best_fit_partition_allocator_unit.sv
// Best-fit partition allocator: a chain of MAX_BLOCKS partition cells.
// An allocate sends a search token down the chain, one cell per cycle, and its
// result goes to the pending result register at the chain's end; clear, add and
// unknown actions load that register directly. The result moves on to the output
// register when it is free, and only then is a new request taken. Reset
// (rst_ni, async, active low) empties the table; stored sizes are not cleared.
`include "best_fit_partition_allocator_unit_defines.svh"

module best_fit_partition_allocator_unit #(
  parameter int MAX_BLOCKS = bfpa_pkg::DefaultMaxBlocks,
  parameter int SIZE_BITS  = bfpa_pkg::DefaultSizeBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfpa_in_if.sink   in_i,
  bfpa_out_if.source out_o
);

  localparam int IdxW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntW    = $clog2(MAX_BLOCKS + 1);
  localparam int OutIdxW = bfpa_pkg::IdxFieldW;
  localparam int OutSzW  = bfpa_pkg::SizeFieldW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  // Search token chain: stage 0 is driven here, stage k leaves cell k-1.
  bfpa_pkg::tok_ctrl_t  tok_ctrl  [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] tok_req   [0:MAX_BLOCKS];
  logic [IdxW-1:0]      tok_idx   [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] tok_rem   [0:MAX_BLOCKS];
  logic [SIZE_BITS-1:0] tok_total [0:MAX_BLOCKS];
  logic [MAX_BLOCKS:0]  tok_vld_vec;

  // Broadcast write port into the cells.
  bfpa_pkg::wr_ctrl_t   wr_ctrl;
  logic [IdxW-1:0]      wr_idx;
  logic [SIZE_BITS-1:0] wr_total;
  logic [SIZE_BITS-1:0] wr_rem;

  bfpa_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;

  // Pending result, held until the output register is free.
  logic                 res_ok_q, res_ok_d;
  logic [IdxW-1:0]      res_idx_q, res_idx_d;
  logic [SIZE_BITS-1:0] res_total_q, res_total_d;
  logic [SIZE_BITS-1:0] res_left_q, res_left_d;
  logic                 res_load;

  // Output register.
  logic                 out_vld_q;
  logic                 out_ok_q;
  logic [OutIdxW-1:0]   out_idx_q;
  logic [OutSzW-1:0]    out_total_q;
  logic [OutSzW-1:0]    out_left_q;
  logic                 out_load;

  logic                 in_xfer;
  logic                 start;
  logic [SIZE_BITS-1:0] in_size;
  logic                 scan_end;
  logic [SIZE_BITS-1:0] alloc_left;

  assign in_xfer    = in_i.valid && in_i.ready;
  assign in_size    = SIZE_BITS'(in_i.item_size);
  assign scan_end   = (state_q == bfpa_pkg::S_SCAN) && tok_ctrl[MAX_BLOCKS].vld;
  assign alloc_left = tok_rem[MAX_BLOCKS] - tok_req[MAX_BLOCKS];

  // The token enters cell 0 in the cycle the allocate request is taken.
  assign tok_ctrl[0].vld   = start;
  assign tok_ctrl[0].found = 1'b0;
  assign tok_req[0]        = in_size;
  assign tok_idx[0]        = '0;
  assign tok_rem[0]        = '0;
  assign tok_total[0]      = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    bfpa_cell #(
      .CELL_ID   (g),
      .MAX_BLOCKS(MAX_BLOCKS),
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .tok_ctrl_i (tok_ctrl[g]),
      .tok_req_i  (tok_req[g]),
      .tok_idx_i  (tok_idx[g]),
      .tok_rem_i  (tok_rem[g]),
      .tok_total_i(tok_total[g]),
      .tok_ctrl_o (tok_ctrl[g+1]),
      .tok_req_o  (tok_req[g+1]),
      .tok_idx_o  (tok_idx[g+1]),
      .tok_rem_o  (tok_rem[g+1]),
      .tok_total_o(tok_total[g+1]),
      .wr_ctrl_i  (wr_ctrl),
      .wr_idx_i   (wr_idx),
      .wr_total_i (wr_total),
      .wr_rem_i   (wr_rem)
    );
  end

  for (genvar g = 0; g <= MAX_BLOCKS; g++) begin : g_vld
    assign tok_vld_vec[g] = tok_ctrl[g].vld;
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfpa_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (bfpa_pkg::action_e'(in_i.action) == bfpa_pkg::ACT_ALLOC) begin
            state_d = bfpa_pkg::S_SCAN;
          end else begin
            state_d = bfpa_pkg::S_DONE;
          end
        end
      end
      bfpa_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = bfpa_pkg::S_DONE;
        end
      end
      bfpa_pkg::S_DONE: begin
        if (out_load) begin
          state_d = bfpa_pkg::S_IDLE;
        end
      end
      default: state_d = bfpa_pkg::S_IDLE;
    endcase
  end

  // Output logic: handshakes, table writes, fill count and pending result.
  always_comb begin
    in_i.ready  = 1'b0;
    start       = 1'b0;
    out_load    = 1'b0;
    res_load    = 1'b0;
    count_d     = count_q;
    wr_ctrl     = '0;
    wr_idx      = count_q[IdxW-1:0];
    wr_total    = in_size;
    wr_rem      = in_size;
    res_ok_d    = 1'b0;
    res_idx_d   = '0;
    res_total_d = '0;
    res_left_d  = '0;
    unique case (state_q)
      bfpa_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_xfer) begin
          res_load = 1'b1;
          unique case (bfpa_pkg::action_e'(in_i.action))
            bfpa_pkg::ACT_CLEAR: begin
              count_d  = '0;
              res_ok_d = 1'b1;
            end
            bfpa_pkg::ACT_ADD: begin
              // A full table rejects the add and leaves everything as is.
              if (count_q < CntMax) begin
                wr_ctrl.en        = 1'b1;
                wr_ctrl.set_total = 1'b1;
                count_d           = count_q + 1'b1;
                res_ok_d          = 1'b1;
                res_idx_d         = count_q[IdxW-1:0];
                res_total_d       = in_size;
                res_left_d        = in_size;
              end
            end
            bfpa_pkg::ACT_ALLOC: begin
              start    = 1'b1;
              res_load = 1'b0;
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end
      bfpa_pkg::S_SCAN: begin
        if (scan_end) begin
          res_load = 1'b1;
          // The winning cell's remaining size shrinks by the request.
          if (tok_ctrl[MAX_BLOCKS].found) begin
            wr_ctrl.en  = 1'b1;
            wr_idx      = tok_idx[MAX_BLOCKS];
            wr_rem      = alloc_left;
            res_ok_d    = 1'b1;
            res_idx_d   = tok_idx[MAX_BLOCKS];
            res_total_d = tok_total[MAX_BLOCKS];
            res_left_d  = alloc_left;
          end
        end
      end
      bfpa_pkg::S_DONE: begin
        out_load = !out_vld_q || out_o.ready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfpa_pkg::S_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_ok_q    <= res_ok_d;
      res_idx_q   <= res_idx_d;
      res_total_q <= res_total_d;
      res_left_q  <= res_left_d;
    end
    if (out_load) begin
      out_ok_q    <= res_ok_q;
      out_idx_q   <= OutIdxW'(res_idx_q);
      out_total_q <= OutSzW'(res_total_q);
      out_left_q  <= OutSzW'(res_left_q);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.ok          = out_ok_q;
  assign out_o.block_index = out_idx_q;
  assign out_o.block_total = out_total_q;
  assign out_o.left_over   = out_left_q;

  // Only one search may be in flight along the chain.
  `BFPA_ASSERT_IMP(a_one_token, clk_i, rst_ni, 1'b1, $onehot0(tok_vld_vec), "two search tokens in chain")
  // A token reaching the end of the chain belongs to a running scan.
  `BFPA_ASSERT_IMP(a_tok_in_scan, clk_i, rst_ni, tok_ctrl[MAX_BLOCKS].vld, state_q == bfpa_pkg::S_SCAN, "token outside scan")
  // A taken request always leaves the idle state on the next cycle.
  `BFPA_ASSERT_NXT(a_leave_idle, clk_i, rst_ni, in_xfer, state_q != bfpa_pkg::S_IDLE, "request taken but still idle")
  // The fill count never passes the table depth.
  `BFPA_ASSERT_IMP(a_count_max, clk_i, rst_ni, 1'b1, count_q <= CntMax, "fill count overflow")

endmodule
